// File: sv/lpfs_pkg.sv
`timescale 1ns / 1ps

package lpfs_pkg;

    // receive store size and pixel count of the strip
    localparam int unsigned BUFFER_BYTES = 4096;
    localparam int unsigned PIXELS       = 64;

    // held byte count runs from zero up to the full store size
    localparam int unsigned HELD_W = $clog2(BUFFER_BYTES + 1);
    // any frame that can complete has a payload length below the store size
    localparam int unsigned LEN_W  = $clog2(BUFFER_BYTES);
    localparam int unsigned PLEN_W = 10;
    localparam int unsigned SUM_W  = ((HELD_W > PLEN_W) ? HELD_W : PLEN_W) + 1;

    // frame width divisor: one pixel takes three bytes
    localparam int unsigned WIDTH_DIV = PIXELS * 3;
    // round-up reciprocal, exact for every length below 2**LEN_W
    localparam int unsigned DIV_SHIFT = LEN_W + $clog2(WIDTH_DIV);
    localparam int unsigned RECIP_W   = DIV_SHIFT + 1;
    localparam int unsigned PROD_W    = LEN_W + RECIP_W;
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << DIV_SHIFT) + 64'(WIDTH_DIV) - 64'd1) / 64'(WIDTH_DIV);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

    // result kinds
    localparam logic [1:0] KIND_HELLO = 2'd0;
    localparam logic [1:0] KIND_BEGIN = 2'd1;
    localparam logic [1:0] KIND_DATA  = 2'd2;
    localparam logic [1:0] KIND_END   = 2'd3;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_HELLO = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BEGIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_END   = 2'd3;

    typedef struct packed {
        logic [7:0]        link_byte;
        logic              packet_first;
        logic [PLEN_W-1:0] packet_length;
    } link_item_t;

    typedef struct packed {
        logic [1:0]  message_kind;
        logic [31:0] message_value;
        logic [7:0]  payload_byte;
        logic        payload_valid;
        logic        frame_last;
    } msg_item_t;

    typedef struct packed {
        logic [7:0] hello_code;
        logic [7:0] begin_code;
        logic [7:0] data_code;
        logic [7:0] end_code;
    } codes_t;

endpackage

// File: sv/lpfs_core.sv
`timescale 1ns / 1ps

module lpfs_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  lpfs_pkg::link_item_t item,
    input  lpfs_pkg::codes_t    codes,
    output logic                res_valid,
    output lpfs_pkg::msg_item_t res
);

    localparam logic [1:0] PH_LENGTH  = 2'd0;
    localparam logic [1:0] PH_HEADER  = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;
    localparam logic [1:0] PH_STALLED = 2'd3;

    localparam logic [2:0] HDR_HELLO = 3'd0;
    localparam logic [2:0] HDR_BEGIN = 3'd1;
    localparam logic [2:0] HDR_DATA  = 3'd2;
    localparam logic [2:0] HDR_END   = 3'd3;
    localparam logic [2:0] HDR_NONE  = 3'd4;

    logic [1:0]                  phase_reg, phase_next;
    logic [31:0]                 acc_reg, acc_next;
    logic [1:0]                  lbi_reg, lbi_next;
    logic [7:0]                  header_reg, header_next;
    logic [lpfs_pkg::LEN_W-1:0]  pidx_reg, pidx_next;
    logic [7:0]                  first_reg, first_next;
    logic [lpfs_pkg::HELD_W-1:0] held_reg, held_next;
    logic                        drop_reg, drop_next;
    logic [lpfs_pkg::LEN_W-1:0]  width_reg, width_next;

    logic [lpfs_pkg::SUM_W-1:0]  sum_first;
    logic                        drop_now;
    logic [lpfs_pkg::PROD_W-1:0] width_prod;
    logic [2:0]                  hdr_kind;
    logic [lpfs_pkg::LEN_W:0]    pidx_inc;
    logic                        last;
    logic                        done;
    logic [7:0]                  fp;

    // priority: hello, then begin, data, end
    function automatic logic [2:0] decode(input logic [7:0] hdr, input lpfs_pkg::codes_t c);
        logic [2:0] k;
        if (hdr == c.hello_code)
            k = HDR_HELLO;
        else if (hdr == c.begin_code)
            k = HDR_BEGIN;
        else if (hdr == c.data_code)
            k = HDR_DATA;
        else if (hdr == c.end_code)
            k = HDR_END;
        else
            k = HDR_NONE;
        return k;
    endfunction

    // frame width = length / (pixels * 3) by reciprocal multiply
    assign width_prod = lpfs_pkg::PROD_W'(acc_reg[lpfs_pkg::LEN_W-1:0]) *
                        lpfs_pkg::PROD_W'(lpfs_pkg::RECIP);

    always_comb
    begin
        phase_next  = phase_reg;
        acc_next    = acc_reg;
        lbi_next    = lbi_reg;
        header_next = header_reg;
        pidx_next   = pidx_reg;
        first_next  = first_reg;
        held_next   = held_reg;
        drop_next   = drop_reg;
        width_next  = width_reg;
        res_valid   = 1'b0;
        res         = '0;
        done        = 1'b0;
        last        = 1'b0;
        fp          = 8'd0;
        hdr_kind    = HDR_NONE;
        pidx_inc    = {1'b0, pidx_reg} + 1'b1;

        sum_first = lpfs_pkg::SUM_W'(held_reg) + lpfs_pkg::SUM_W'(item.packet_length);
        drop_now  = item.packet_first ?
                    (sum_first > lpfs_pkg::SUM_W'(lpfs_pkg::BUFFER_BYTES)) : drop_reg;

        if (step)
        begin
            drop_next = drop_now;
            if (!drop_now)
            begin
                if (held_reg == lpfs_pkg::HELD_W'(lpfs_pkg::BUFFER_BYTES))
                begin
                    drop_next = 1'b1;
                end
                else
                begin
                    held_next = held_reg + 1'b1;
                    case (phase_reg)
                        PH_LENGTH:
                        begin
                            acc_next = acc_reg | (32'(item.link_byte) << {lbi_reg, 3'b000});
                            lbi_next = lbi_reg + 1'b1;
                            if (lbi_reg == 2'd3)
                                phase_next = PH_HEADER;
                        end
                        PH_HEADER:
                        begin
                            header_next = item.link_byte;
                            pidx_next   = '0;
                            first_next  = 8'd0;
                            width_next  = width_prod[lpfs_pkg::DIV_SHIFT +: lpfs_pkg::LEN_W];
                            hdr_kind    = decode(item.link_byte, codes);
                            if (({1'b0, acc_reg} + 33'd5) > 33'(lpfs_pkg::BUFFER_BYTES))
                            begin
                                phase_next = PH_STALLED;
                            end
                            else if (acc_reg == 32'd0)
                            begin
                                done = 1'b1;
                                last = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_PAYLOAD;
                            end
                        end
                        PH_PAYLOAD:
                        begin
                            if (pidx_reg == '0)
                                first_next = item.link_byte;
                            pidx_next = pidx_inc[lpfs_pkg::LEN_W-1:0];
                            last      = pidx_inc >= {1'b0, acc_reg[lpfs_pkg::LEN_W-1:0]};
                            fp        = (pidx_reg == '0) ? item.link_byte : first_reg;
                            hdr_kind  = decode(header_reg, codes);
                            done      = last;
                            if (hdr_kind == HDR_DATA)
                            begin
                                res_valid         = 1'b1;
                                res.message_kind  = lpfs_pkg::KIND_DATA;
                                res.message_value = 32'(width_reg);
                                res.payload_byte  = item.link_byte;
                                res.payload_valid = 1'b1;
                                res.frame_last    = last;
                            end
                        end
                        default:
                        begin
                        end
                    endcase

                    // end of frame result for empty frames and control frames
                    if (done && !(phase_reg == PH_PAYLOAD && hdr_kind == HDR_DATA))
                    begin
                        res.frame_last = 1'b1;
                        case (hdr_kind)
                            HDR_HELLO:
                            begin
                                res_valid         = 1'b1;
                                res.message_kind  = lpfs_pkg::KIND_HELLO;
                                res.message_value = 32'(lpfs_pkg::PIXELS);
                            end
                            HDR_BEGIN:
                            begin
                                res_valid         = 1'b1;
                                res.message_kind  = lpfs_pkg::KIND_BEGIN;
                                res.message_value = 32'(fp);
                            end
                            HDR_DATA:
                            begin
                                res_valid         = 1'b1;
                                res.message_kind  = lpfs_pkg::KIND_DATA;
                            end
                            HDR_END:
                            begin
                                res_valid         = 1'b1;
                                res.message_kind  = lpfs_pkg::KIND_END;
                                res.message_value = 32'(fp);
                            end
                            default:
                            begin
                                res_valid = 1'b0;
                            end
                        endcase
                    end

                    if (done)
                    begin
                        held_next  = '0;
                        phase_next = PH_LENGTH;
                        acc_next   = 32'd0;
                        lbi_next   = 2'd0;
                        pidx_next  = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_LENGTH;
            acc_reg    <= 32'd0;
            lbi_reg    <= 2'd0;
            header_reg <= 8'd0;
            pidx_reg   <= '0;
            first_reg  <= 8'd0;
            held_reg   <= '0;
            drop_reg   <= 1'b0;
            width_reg  <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            acc_reg    <= acc_next;
            lbi_reg    <= lbi_next;
            header_reg <= header_next;
            pidx_reg   <= pidx_next;
            first_reg  <= first_next;
            held_reg   <= held_next;
            drop_reg   <= drop_next;
            width_reg  <= width_next;
        end
    end

endmodule

// File: sv/length_prefixed_frame_splitter.sv
`timescale 1ns / 1ps

// Splits a stream of link packet bytes into length-prefixed frames (4-byte
// little-endian length, header byte, payload) and gives one message per hello,
// begin or end frame and one per data payload byte (one with no byte for an
// empty data frame). Throughput is one link byte per clock while the output
// slot is free or being emptied: each byte passes an input register, the
// combinational frame logic and an output register. Packets that would
// overfill the 4096-byte receive store are dropped whole, and a frame too
// large for the store stops parsing until reset but still takes bytes. Header
// codes are programmable through the cfg port (index 0 hello, 1 begin, 2
// data, 3 end) and should be written only while no link bytes are in flight;
// the cfg port is always ready. No clearing pass is needed after reset.
module length_prefixed_frame_splitter (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 link_valid,
    output logic                                 link_ready,
    input  lpfs_pkg::link_item_t                 link_item,
    output logic                                 msg_valid,
    input  logic                                 msg_ready,
    output lpfs_pkg::msg_item_t                  msg_item,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [lpfs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [7:0]                           cfg_data
);

    // input register stage
    logic                  stage_valid_reg;
    lpfs_pkg::link_item_t  stage_item_reg;

    // output register stage
    logic                  out_valid_reg;
    lpfs_pkg::msg_item_t   out_item_reg;

    // header code registers
    lpfs_pkg::codes_t      codes_reg;

    logic                  advance;
    logic                  res_valid;
    lpfs_pkg::msg_item_t   res;

    // the staged byte moves on whenever the output slot is free or being emptied
    assign advance    = stage_valid_reg && (!out_valid_reg || msg_ready);
    assign link_ready = !stage_valid_reg || advance;
    assign msg_valid  = out_valid_reg;
    assign msg_item   = out_item_reg;
    assign cfg_ready  = 1'b1;

    lpfs_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .item      (stage_item_reg),
        .codes     (codes_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (link_valid && link_ready)
                stage_valid_reg <= 1'b1;
            else if (advance)
                stage_valid_reg <= 1'b0;

            // a byte without a message still frees the slot once it is taken
            if (advance)
                out_valid_reg <= res_valid;
            else if (msg_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (link_valid && link_ready)
            stage_item_reg <= link_item;
        if (advance && res_valid)
            out_item_reg <= res;
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            codes_reg.hello_code <= 8'd0;
            codes_reg.begin_code <= 8'd1;
            codes_reg.data_code  <= 8'd2;
            codes_reg.end_code   <= 8'd3;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                lpfs_pkg::CFG_HELLO: codes_reg.hello_code <= cfg_data;
                lpfs_pkg::CFG_BEGIN: codes_reg.begin_code <= cfg_data;
                lpfs_pkg::CFG_DATA:  codes_reg.data_code  <= cfg_data;
                lpfs_pkg::CFG_END:   codes_reg.end_code   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // only data messages carry a payload byte
    a_payload_only_data: assert property (@(posedge clk) disable iff (!rst_n)
        msg_valid && msg_item.payload_valid |-> msg_item.message_kind == lpfs_pkg::KIND_DATA)
        else $error("payload byte flagged on a non-data message");

    // a byte with no payload flag must read as zero
    a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
        msg_valid && !msg_item.payload_valid |-> msg_item.payload_byte == 8'd0)
        else $error("payload byte not zero without payload flag");

    // control messages always close their frame
    a_control_last: assert property (@(posedge clk) disable iff (!rst_n)
        msg_valid && msg_item.message_kind != lpfs_pkg::KIND_DATA |-> msg_item.frame_last)
        else $error("control message without frame end");

    // a staged byte that cannot move on is kept
    a_stage_kept: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid_reg && !advance |=> stage_valid_reg && $stable(stage_item_reg))
        else $error("staged link byte lost");

endmodule

// File: sim/lpfs_frame_checker.sv
`timescale 1ns / 1ps

module lpfs_frame_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           link_valid,
    input  logic                           link_ready,
    input  lpfs_pkg::link_item_t           link_item,
    input  logic                           msg_valid,
    input  logic                           msg_ready,
    input  lpfs_pkg::msg_item_t            msg_item,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [lpfs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_data,
    output int unsigned                    pending,
    output int unsigned                    fails,
    output int unsigned                    checked
);

    typedef enum logic [1:0] {
        WAIT_LENGTH,
        WAIT_HEADER,
        IN_PAYLOAD,
        STALLED
    } parse_phase_t;

    typedef enum logic [2:0] {
        FRAME_HELLO,
        FRAME_BEGIN,
        FRAME_DATA,
        FRAME_END,
        FRAME_OTHER
    } frame_class_t;

    lpfs_pkg::codes_t            codes;
    parse_phase_t                parse_phase;
    logic [31:0]                 len_acc;
    logic [1:0]                  len_idx;
    logic [7:0]                  hdr;
    logic [31:0]                 pay_idx;
    logic [7:0]                  first_pay;
    logic [lpfs_pkg::HELD_W-1:0] held;
    logic                        dropping;
    lpfs_pkg::msg_item_t         expected_msgs[$];
    lpfs_pkg::msg_item_t         want_msg;

    function automatic lpfs_pkg::msg_item_t make_msg(input logic [1:0] kind,
                                                     input logic [31:0] value,
                                                     input logic [7:0] data,
                                                     input logic data_ok,
                                                     input logic last);
        lpfs_pkg::msg_item_t m;
        m.message_kind  = kind;
        m.message_value = value;
        m.payload_byte  = data;
        m.payload_valid = data_ok;
        m.frame_last    = last;
        return m;
    endfunction

    // hello wins over begin, begin over data, data over end
    function automatic frame_class_t classify(input logic [7:0] h);
        if (h == codes.hello_code)
            return FRAME_HELLO;
        if (h == codes.begin_code)
            return FRAME_BEGIN;
        if (h == codes.data_code)
            return FRAME_DATA;
        if (h == codes.end_code)
            return FRAME_END;
        return FRAME_OTHER;
    endfunction

    task automatic push_control(input frame_class_t fc);
        logic [31:0] fp;
        fp = (len_acc == 32'd0) ? 32'd0 : 32'(first_pay);
        case (fc)
            FRAME_HELLO: expected_msgs.push_back(make_msg(lpfs_pkg::KIND_HELLO,
                                                          32'(lpfs_pkg::PIXELS),
                                                          8'd0, 1'b0, 1'b1));
            FRAME_BEGIN: expected_msgs.push_back(make_msg(lpfs_pkg::KIND_BEGIN, fp,
                                                          8'd0, 1'b0, 1'b1));
            FRAME_END:   expected_msgs.push_back(make_msg(lpfs_pkg::KIND_END, fp,
                                                          8'd0, 1'b0, 1'b1));
            default:     ;
        endcase
    endtask

    task automatic close_frame();
        held        = '0;
        parse_phase = WAIT_LENGTH;
        len_acc     = 32'd0;
        len_idx     = 2'd0;
        pay_idx     = 32'd0;
    endtask

    task automatic advance_deframer(input lpfs_pkg::link_item_t it);
        frame_class_t fc;
        logic         last;
        if (it.packet_first)
            dropping = (int'(held) + int'(it.packet_length)) > int'(lpfs_pkg::BUFFER_BYTES);
        if (dropping)
            return;
        if (int'(held) + 1 > int'(lpfs_pkg::BUFFER_BYTES))
        begin
            dropping = 1'b1;
            return;
        end
        held = held + 1'b1;
        case (parse_phase)
            WAIT_LENGTH:
            begin
                len_acc = len_acc | (32'(it.link_byte) << {len_idx, 3'b000});
                len_idx = len_idx + 2'd1;
                if (len_idx == 2'd0)
                    parse_phase = WAIT_HEADER;
            end
            WAIT_HEADER:
            begin
                hdr       = it.link_byte;
                pay_idx   = 32'd0;
                first_pay = 8'd0;
                fc        = classify(hdr);
                if ({1'b0, len_acc} + 33'd5 > 33'(lpfs_pkg::BUFFER_BYTES))
                begin
                    parse_phase = STALLED;
                end
                else if (len_acc == 32'd0)
                begin
                    if (fc == FRAME_DATA)
                        expected_msgs.push_back(make_msg(lpfs_pkg::KIND_DATA, 32'd0, 8'd0,
                                                         1'b0, 1'b1));
                    else
                        push_control(fc);
                    close_frame();
                end
                else
                begin
                    parse_phase = IN_PAYLOAD;
                end
            end
            IN_PAYLOAD:
            begin
                if (pay_idx == 32'd0)
                    first_pay = it.link_byte;
                pay_idx = pay_idx + 32'd1;
                last    = (pay_idx >= len_acc);
                fc      = classify(hdr);
                if (fc == FRAME_DATA)
                    expected_msgs.push_back(make_msg(lpfs_pkg::KIND_DATA,
                                                     len_acc / 32'(lpfs_pkg::PIXELS * 3),
                                                     it.link_byte, 1'b1, last));
                else if (last)
                    push_control(fc);
                if (last)
                    close_frame();
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        fails = fails + 1;
        if (fails <= 40)
            $display("%0t ns: message %0d %s: got %0h, want %0h", $time, checked, what, got,
                     want);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            codes.hello_code = 8'd0;
            codes.begin_code = 8'd1;
            codes.data_code  = 8'd2;
            codes.end_code   = 8'd3;
            parse_phase      = WAIT_LENGTH;
            len_acc          = 32'd0;
            len_idx          = 2'd0;
            hdr              = 8'd0;
            pay_idx          = 32'd0;
            first_pay        = 8'd0;
            held             = '0;
            dropping         = 1'b0;
            expected_msgs.delete();
            pending          = 0;
            fails            = 0;
            checked          = 0;
        end
        else
        begin
            // results leave through the input and output registers after their byte, so compare first
            if (msg_valid && msg_ready)
            begin
                if (expected_msgs.size() == 0)
                begin
                    report_mismatch("arrived with nothing expected", msg_item.message_value, 0);
                end
                else
                begin
                    want_msg = expected_msgs.pop_front();
                    if (msg_item.message_kind != want_msg.message_kind)
                        report_mismatch("kind", msg_item.message_kind, want_msg.message_kind);
                    if (msg_item.message_value != want_msg.message_value)
                        report_mismatch("value", msg_item.message_value, want_msg.message_value);
                    if (msg_item.payload_byte != want_msg.payload_byte)
                        report_mismatch("payload byte", msg_item.payload_byte,
                                        want_msg.payload_byte);
                    if (msg_item.payload_valid != want_msg.payload_valid)
                        report_mismatch("payload valid", msg_item.payload_valid,
                                        want_msg.payload_valid);
                    if (msg_item.frame_last != want_msg.frame_last)
                        report_mismatch("frame last", msg_item.frame_last, want_msg.frame_last);
                    checked = checked + 1;
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    lpfs_pkg::CFG_HELLO: codes.hello_code = cfg_data;
                    lpfs_pkg::CFG_BEGIN: codes.begin_code = cfg_data;
                    lpfs_pkg::CFG_DATA:  codes.data_code  = cfg_data;
                    lpfs_pkg::CFG_END:   codes.end_code   = cfg_data;
                    default:   ;
                endcase
            end
            if (link_valid && link_ready)
                advance_deframer(link_item);
            pending = expected_msgs.size();
        end
    end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

    // cycles without any accepted request before the run is called hung
    localparam int STALL_LIMIT = 4000;
    // how long the receiver refuses messages when asked to hold off
    localparam int HOLD_CYCLES = 400;
    // random bytes per code setting
    localparam int PHASE_BYTES = 120;

    logic                           clk;
    logic                           rst_n;
    logic                           link_valid;
    logic                           link_ready;
    lpfs_pkg::link_item_t           link_item;
    logic                           msg_valid;
    logic                           msg_ready;
    lpfs_pkg::msg_item_t            msg_item;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [lpfs_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [7:0]                     cfg_data;

    int unsigned pending;
    int unsigned fails;
    int unsigned checked;

    // stimulus side bookkeeping
    lpfs_pkg::codes_t codes;   // header codes as last written
    int     pkt_left;       // bytes still to go in the packet being sent
    int     burst_left;     // requests left in the current sender burst
    bit     gaps_on;        // sender idles between bursts
    int     rx_mode;        // receiver stall pattern
    bit     want_hold;      // asks the receiver for one long hold-off
    int     sent_bytes;
    int     idle_cycles;

    length_prefixed_frame_splitter dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .link_valid (link_valid),
        .link_ready (link_ready),
        .link_item  (link_item),
        .msg_valid  (msg_valid),
        .msg_ready  (msg_ready),
        .msg_item   (msg_item),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    lpfs_frame_checker frame_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .link_valid (link_valid),
        .link_ready (link_ready),
        .link_item  (link_item),
        .msg_valid  (msg_valid),
        .msg_ready  (msg_ready),
        .msg_item   (msg_item),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pending    (pending),
        .fails      (fails),
        .checked    (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver: a stall pattern per phase, plus one long hold-off on request
    initial
    begin : receiver
        int hold_left;
        int beat;
        msg_ready = 1'b0;
        hold_left = 0;
        beat      = 0;
        forever
        begin
            @(negedge clk);
            beat = beat + 1;
            if (want_hold)
            begin
                hold_left = HOLD_CYCLES;
                want_hold = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                msg_ready <= 1'b0;
            end
            else
            begin
                case (rx_mode)
                    0:       msg_ready <= 1'b1;
                    1:       msg_ready <= ($urandom_range(0, 99) < 60);
                    2:       msg_ready <= ((beat % 11) < 7);
                    default: msg_ready <= ($urandom_range(0, 99) < 20);
                endcase
            end
        end
    end

    // watchdog: any accepted request on any channel counts as progress
    always @(posedge clk)
    begin
        if (!rst_n || (link_valid && link_ready) || (msg_valid && msg_ready) ||
            (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("no request accepted for %0d cycles, %0d messages outstanding",
                         idle_cycles, pending);
                $display("[length_prefixed_frame_splitter] ERROR");
                $finish;
            end
        end
    end

    // one link byte request; entered and left at a falling edge
    task automatic send_link(input lpfs_pkg::link_item_t it);
        int gap;
        if (burst_left == 0)
        begin
            gap = gaps_on ? $urandom_range(0, 12) : 0;
            if (gap > 0)
            begin
                link_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        link_valid <= 1'b1;
        link_item  <= it;
        @(posedge clk);
        while (!link_ready)
            @(posedge clk);
        @(negedge clk);
        burst_left = burst_left - 1;
        sent_bytes = sent_bytes + 1;
    endtask

    // one frame byte; pos is the number of frame bytes held ahead of it, so a new
    // packet is always declared small enough to fit the store
    task automatic put_byte(input logic [7:0] b, input int pos);
        lpfs_pkg::link_item_t it;
        int         room;
        int         actual;
        it.link_byte = b;
        if (pkt_left == 0)
        begin
            room = int'(lpfs_pkg::BUFFER_BYTES) - pos;
            if (room > 512)
                room = 512;
            actual = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 512)
                                                 : $urandom_range(1, 24);
            it.packet_first = 1'b1;
            // declared length often disagrees with the bytes actually sent
            if ($urandom_range(0, 3) == 0)
                it.packet_length = lpfs_pkg::PLEN_W'($urandom_range(1, room));
            else
                it.packet_length = lpfs_pkg::PLEN_W'((actual > room) ? room : actual);
            pkt_left = actual;
        end
        else
        begin
            it.packet_first  = 1'b0;
            it.packet_length = lpfs_pkg::PLEN_W'($urandom_range(0, 1023));
        end
        pkt_left = pkt_left - 1;
        send_link(it);
    endtask

    // a packet of junk declared too long for the room left, so it is dropped whole
    task automatic drop_packet(input int pos);
        lpfs_pkg::link_item_t it;
        int         n;
        int         k;
        it.packet_first  = 1'b1;
        it.packet_length =
            lpfs_pkg::PLEN_W'($urandom_range(int'(lpfs_pkg::BUFFER_BYTES) - pos + 1, 512));
        n = $urandom_range(1, 6);
        for (k = 0; k < n; k++)
        begin
            it.link_byte = 8'($urandom_range(0, 255));
            send_link(it);
            it.packet_first  = 1'b0;
            it.packet_length = lpfs_pkg::PLEN_W'($urandom_range(0, 1023));
        end
        pkt_left = 0;
    endtask

    // fill below zero means random payload bytes
    task automatic send_frame(input logic [7:0] hdr, input logic [31:0] len,
                              input bit with_drops, input int fill);
        int i;
        int pos;
        pos = 0;
        for (i = 0; i < 4; i++)
        begin
            put_byte(len[8*i +: 8], pos);
            pos = pos + 1;
        end
        put_byte(hdr, pos);
        pos = pos + 1;
        for (i = 0; i < int'(len); i++)
        begin
            if (with_drops && pos > int'(lpfs_pkg::BUFFER_BYTES) - 512 &&
                $urandom_range(0, 63) == 0)
                drop_packet(pos);
            put_byte((fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill), pos);
            pos = pos + 1;
        end
    endtask

    task automatic pick_header(output logic [7:0] h);
        case ($urandom_range(0, 4))
            0: h = codes.hello_code;
            1: h = codes.begin_code;
            2: h = codes.data_code;
            3: h = codes.end_code;
            default:
            begin
                // a header that names no frame kind
                h = 8'($urandom_range(0, 255));
                while (h == codes.hello_code || h == codes.begin_code ||
                       h == codes.data_code || h == codes.end_code)
                    h = h + 8'd1;
            end
        endcase
    endtask

    // well-formed frames with random headers, lengths and content
    task automatic run_random_frames(input int budget);
        int          start;
        logic [7:0]  h;
        logic [31:0] len;
        int          r;
        start = sent_bytes;
        while (sent_bytes - start < budget)
        begin
            pick_header(h);
            r = $urandom_range(0, 99);
            if (r < 55)
                len = $urandom_range(0, 6);
            else if (r < 95)
                len = $urandom_range(7, 40);
            else
                len = $urandom_range(192, 420);
            send_frame(h, len, 1'b0, -1);
        end
    endtask

    // sender pauses until every expected message is out
    task automatic drain();
        link_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
    endtask

    task automatic write_reg(input logic [lpfs_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // only called with the block idle and the byte stream on a frame boundary
    task automatic write_codes(input lpfs_pkg::codes_t c);
        drain();
        // bytes that give no message may still be in the pipeline
        repeat (8) @(negedge clk);
        write_reg(lpfs_pkg::CFG_HELLO, c.hello_code);
        write_reg(lpfs_pkg::CFG_BEGIN, c.begin_code);
        write_reg(lpfs_pkg::CFG_DATA, c.data_code);
        write_reg(lpfs_pkg::CFG_END, c.end_code);
        cfg_valid <= 1'b0;
        codes = c;
    endtask

    initial
    begin : stimulus
        int                   ph;
        int                   i;
        lpfs_pkg::codes_t     c;
        lpfs_pkg::link_item_t it;
        logic [31:0]          big_len;

        rst_n      = 1'b0;
        link_valid = 1'b0;
        link_item  = '0;
        cfg_valid  = 1'b0;
        cfg_index  = lpfs_pkg::CFG_HELLO;
        cfg_data   = 8'd0;
        want_hold  = 1'b0;
        rx_mode    = 0;
        gaps_on    = 1'b1;
        burst_left = 0;
        sent_bytes = 0;
        // the first few bytes come before any packet start
        pkt_left   = 7;
        codes.hello_code = 8'd0;
        codes.begin_code = 8'd1;
        codes.data_code  = 8'd2;
        codes.end_code   = 8'd3;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed frames on the reset header codes
        send_frame(codes.hello_code, 0, 1'b0, -1);
        send_frame(codes.begin_code, 0, 1'b0, -1);   // empty begin gives speed 0
        send_frame(codes.end_code, 0, 1'b0, -1);     // empty end gives flag 0
        send_frame(codes.data_code, 0, 1'b0, -1);    // empty data: one message, no byte
        send_frame(codes.begin_code, 1, 1'b0, 255);
        send_frame(codes.end_code, 2, 1'b0, 0);
        send_frame(8'h7f, 1, 1'b0, -1);              // unknown header, nothing comes out
        send_frame(codes.data_code, 3, 1'b0, 255);
        send_frame(codes.hello_code, 2, 1'b0, 0);

        // longer frames; three bytes per pixel gives a frame width of one
        rx_mode = 1;
        send_frame(codes.hello_code, 40, 1'b0, -1);
        send_frame(codes.data_code, 32'(lpfs_pkg::PIXELS * 3), 1'b0, -1);

        for (ph = 1; ph <= 8; ph++)
        begin
            case (ph)
                1:       c = '{8'hff, 8'hff, 8'hff, 8'hff};   // hello shadows every kind
                2:       c = '{8'hff, 8'h00, 8'h80, 8'h7f};
                3:       c = '{8'hc8, 8'h05, 8'h05, 8'h05};   // begin shadows data and end
                4:       c = '{8'h00, 8'h00, 8'hff, 8'h01};
                8:       c = '{8'h00, 8'h01, 8'h02, 8'h03};
                default: c = '{8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                               8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))};
            endcase
            write_codes(c);
            rx_mode = ph % 4;
            gaps_on = (ph % 3 != 0);
            if (ph == 2 || ph == 4)
            begin
                // receiver holds off while a long data frame fills the block
                want_hold = 1'b1;
                send_frame(codes.data_code, 150, 1'b0, -1);
            end
            run_random_frames(PHASE_BYTES / 2);
            if (ph == 3 || ph == 6)
                drain();
            run_random_frames(PHASE_BYTES / 2);
        end

        // frame too large for the store: parsing stops for good
        case ($urandom_range(0, 2))
            0:       big_len = 32'(lpfs_pkg::BUFFER_BYTES - 4);
            1:       big_len = 32'hffff_ffff;
            default: big_len = $urandom | 32'h0001_0000;
        endcase
        for (i = 0; i < 4; i++)
            put_byte(big_len[8*i +: 8], i);
        put_byte(8'($urandom_range(0, 255)), 4);
        // a packet declared as one byte that carries many more
        it.packet_first  = 1'b1;
        it.packet_length = lpfs_pkg::PLEN_W'(1);
        for (i = 0; i < 200; i++)
        begin
            it.link_byte = 8'($urandom_range(0, 255));
            send_link(it);
            it.packet_first  = 1'b0;
            it.packet_length = lpfs_pkg::PLEN_W'($urandom_range(0, 1023));
        end
        // noise after the stall: no message ever comes out
        for (i = 0; i < 100; i++)
        begin
            it.link_byte     = 8'($urandom_range(0, 255));
            it.packet_first  = ($urandom_range(0, 3) == 0);
            it.packet_length = lpfs_pkg::PLEN_W'($urandom_range(1, 512));
            send_link(it);
        end

        drain();
        repeat (20) @(negedge clk);

        $display("covered %0d link bytes and %0d checked messages over nine header settings,",
                 sent_bytes, checked);
        $display("with empty and unknown frames, a long receiver hold-off and a stalling frame");
        if (fails == 0 && pending == 0)
        begin
            $display("[length_prefixed_frame_splitter] OK");
        end
        else
        begin
            $display("%0d mismatches, %0d messages still expected", fails, pending);
            $display("[length_prefixed_frame_splitter] ERROR");
        end
        $finish;
    end

endmodule
